### rtl/core/ppr_pkg.sv
// shared types and constants of the pixel prediction residual block
// no dependencies; imported by every module of the block but ppr_ram
package ppr_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CFG_W      = 13;
    localparam int LEN_W      = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int PIX_W      = 8;
    localparam int SMP_W      = 10;
    localparam int IDX_W      = 2;

    typedef enum logic [2:0] {
        MODE_LEFT     = 3'd0,
        MODE_ABOVE    = 3'd1,
        MODE_AVERAGE  = 3'd2,
        MODE_PAETH    = 3'd3,
        MODE_GRADIENT = 3'd4,
        MODE_HALF     = 3'd5
    } pred_mode_t;

    typedef enum logic {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } dir_t;

    typedef enum logic [IDX_W-1:0] {
        REG_MODE      = 2'd0,
        REG_DIRECTION = 2'd1,
        REG_WIDTH     = 2'd2,
        REG_HEIGHT    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [2:0] mode;
        dir_t       direction;
    } pred_cfg_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] result;
        logic                    end_of_image;
    } out_word_t;

endpackage

### rtl/core/ppr_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module ppr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/ppr_predict.sv
// predictor and residual / reconstruction datapath
// depends on ppr_pkg
module ppr_predict (
    input  ppr_pkg::pred_cfg_t                cfg,
    input  logic signed [ppr_pkg::SMP_W-1:0]  sample,
    input  logic [ppr_pkg::PIX_W-1:0]         left,
    input  logic [ppr_pkg::PIX_W-1:0]         above,
    input  logic [ppr_pkg::PIX_W-1:0]         upleft,
    output logic signed [ppr_pkg::SMP_W-1:0]  result,
    output logic [ppr_pkg::PIX_W-1:0]         pixel
);
    import ppr_pkg::*;

    logic signed [10:0] sl, sa, sc;
    logic signed [10:0] diff_ac, diff_bc, diff_p;
    logic signed [10:0] da, db, dc;
    logic signed [10:0] half;
    logic signed [10:0] pred;
    logic signed [10:0] paeth;
    logic signed [11:0] dsum;
    logic signed [10:0] eres;
    logic [PIX_W-1:0]   enc_px;
    logic [PIX_W-1:0]   dec_px;

    always_comb begin
        sl = signed'({3'b000, left});
        sa = signed'({3'b000, above});
        sc = signed'({3'b000, upleft});

        // distances of p = l + a - ul to each neighbor
        diff_bc = sa - sc;
        diff_ac = sl - sc;
        diff_p  = sl + sa - sc - sc;
        da = diff_bc[10] ? -diff_bc : diff_bc;
        db = diff_ac[10] ? -diff_ac : diff_ac;
        dc = diff_p[10]  ? -diff_p  : diff_p;
        if (da <= db && da <= dc) begin
            paeth = sl;
        end else if (db <= dc) begin
            paeth = sa;
        end else begin
            paeth = sc;
        end

        // halve toward zero
        half = (diff_bc + (diff_bc[10] ? 11'sd1 : 11'sd0)) >>> 1;

        case (cfg.mode)
            MODE_LEFT:     pred = sl;
            MODE_ABOVE:    pred = sa;
            MODE_AVERAGE:  pred = (sl + sa) >>> 1;
            MODE_PAETH:    pred = paeth;
            MODE_GRADIENT: pred = sl + sa - sc;
            MODE_HALF:     pred = sl + half;
            default:       pred = '0;
        endcase

        if (sample < 0) begin
            enc_px = '0;
        end else if (sample > 10'sd255) begin
            enc_px = '1;
        end else begin
            enc_px = sample[PIX_W-1:0];
        end
        eres = signed'({3'b000, enc_px}) - pred;

        dsum = 12'(pred) + 12'(sample);
        if (dsum < 0) begin
            dec_px = '0;
        end else if (dsum > 12'sd255) begin
            dec_px = '1;
        end else begin
            dec_px = dsum[PIX_W-1:0];
        end

        if (cfg.direction == DIR_DECODE) begin
            pixel  = dec_px;
            result = signed'({2'b00, dec_px});
        end else begin
            pixel  = enc_px;
            result = eres[SMP_W-1:0];
        end
    end

endmodule

### rtl/core/ppr_skid.sv
// output register with skid stage for the result channel
// depends on ppr_pkg
module ppr_skid (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  ppr_pkg::out_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output ppr_pkg::out_word_t  out_word
);
    import ppr_pkg::*;

    logic      out_valid_reg;
    logic      skid_valid_reg;
    out_word_t out_word_reg;
    out_word_t skid_word_reg;
    logic      in_acc;

    assign in_ready  = !skid_valid_reg;
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_acc;
            end
        end else if (in_acc) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_word_reg <= skid_word_reg;
            end else if (in_acc) begin
                out_word_reg <= in_word;
            end
        end else if (in_acc) begin
            skid_word_reg <= in_word;
        end
    end

`ifndef SYNTHESIS
    // a word only sits in the skid stage behind a stalled output word
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without output word");

    // a stalled output with a new word fills the skid stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ready && in_acc |=> skid_valid_reg)
        else $error("word lost under stall");

    // the skid stage drains into the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && out_ready |=> out_valid_reg && !skid_valid_reg)
        else $error("skid stage did not drain");
`endif

endmodule

### rtl/core/pixel_prediction_residual.sv
// top level of the pixel prediction residual block
// depends on ppr_pkg, ppr_ram, ppr_predict and ppr_skid
//
// usage:
//   samples enter on s_valid/s_ready/s_sample in raster order, one word per
//   pixel. in encode the sample is the pixel and m_result is the residual;
//   in decode the sample is the residual and m_result the rebuilt pixel.
//   m_end_of_image marks the last pixel of the image.
//   registers (mode, direction, width, height) are written through
//   cfg_wr_en/cfg_index/cfg_wdata while no word is in flight.
// output: each result is registered in ppr_skid as its sample is taken.
// throughput: one word per cycle while s_ready is high; the row above is kept
//   in a one-port-write ram that is prefetched one pixel ahead, with the read
//   for the next column issued on the same edge as the current write.
// stall: the output register plus a skid stage hold up to two results;
//   s_ready drops only when both are full.
// reset: the position returns to the first pixel and the registers go to
//   left mode, encode, 256 x 256. the row ram is not cleared; the first row
//   does not use what it reads.
module pixel_prediction_residual (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [ppr_pkg::IDX_W-1:0]          cfg_index,
    input  logic [ppr_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [ppr_pkg::SMP_W-1:0]   s_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [ppr_pkg::SMP_W-1:0]   m_result,
    output logic                               m_end_of_image
);
    import ppr_pkg::*;

    logic [2:0]       mode_reg;
    dir_t             direction_reg;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [PIX_W-1:0] left_reg;
    logic [PIX_W-1:0] upleft_reg;
    logic             fwd_reg;
    logic [PIX_W-1:0] fwd_px_reg;

    logic [LEN_W-1:0] w_eff;
    logic [CFG_W-1:0] h_eff;
    logic             row_end, img_end;
    logic             in_acc;
    logic [PIX_W-1:0] ram_rdata;
    logic [PIX_W-1:0] above_raw, l_px, a_px, ul_px;
    logic [PIX_W-1:0] pixel;
    logic signed [SMP_W-1:0] result;
    pred_cfg_t        pcfg;
    out_word_t        res_word, m_word;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_LEFT;
            direction_reg <= DIR_ENCODE;
            width_reg     <= CFG_W'(256);
            height_reg    <= CFG_W'(256);
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_index))
                REG_MODE:      mode_reg      <= cfg_wdata[2:0];
                REG_DIRECTION: direction_reg <= dir_t'(cfg_wdata[0]);
                REG_WIDTH:     width_reg     <= cfg_wdata;
                REG_HEIGHT:    height_reg    <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // effective geometry and position advance
    always_comb begin
        if (width_reg == '0) begin
            w_eff = LEN_W'(1);
        end else if (LEN_W'(width_reg) > LEN_W'(MAX_WIDTH)) begin
            w_eff = LEN_W'(MAX_WIDTH);
        end else begin
            w_eff = LEN_W'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = CFG_W'(1);
        end else if (height_reg > CFG_W'(MAX_HEIGHT)) begin
            h_eff = CFG_W'(MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
        row_end = (LEN_W'(col_reg) + LEN_W'(1)) >= w_eff;
        img_end = row_end && ((CFG_W'(row_reg) + CFG_W'(1)) >= h_eff);
        if (img_end) begin
            col_next = '0;
            row_next = '0;
        end else if (row_end) begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end else begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    assign in_acc = s_valid && s_ready;

    // row store: write current pixel, prefetch the entry of the next position
    ppr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_ram (
        .clk   (aclk),
        .we    (in_acc),
        .waddr (col_reg),
        .wdata (pixel),
        .re    (in_acc),
        .raddr (col_next),
        .rdata (ram_rdata)
    );

    // same column read and written on one edge: take the new pixel
    assign above_raw = fwd_reg ? fwd_px_reg : ram_rdata;
    assign l_px      = (col_reg != '0) ? left_reg : '0;
    assign a_px      = (row_reg != '0) ? above_raw : '0;
    assign ul_px     = (col_reg != '0 && row_reg != '0) ? upleft_reg : '0;

    assign pcfg.mode      = mode_reg;
    assign pcfg.direction = direction_reg;

    ppr_predict u_predict (
        .cfg    (pcfg),
        .sample (s_sample),
        .left   (l_px),
        .above  (a_px),
        .upleft (ul_px),
        .result (result),
        .pixel  (pixel)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
            upleft_reg <= '0;
            fwd_reg    <= 1'b0;
        end else if (in_acc) begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            left_reg   <= pixel;
            upleft_reg <= a_px;
            fwd_reg    <= (col_next == col_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            fwd_px_reg <= pixel;
        end
    end

    assign res_word.result       = result;
    assign res_word.end_of_image = img_end;

    ppr_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_word   (res_word),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (m_word)
    );

    assign m_result       = m_word.result;
    assign m_end_of_image = m_word.end_of_image;

`ifndef SYNTHESIS
    // the last pixel of an image sends the position back to the origin
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && img_end |=> col_reg == '0 && row_reg == '0)
        else $error("position not cleared after last pixel");

    // inside a row the column steps by one and the row holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && !row_end |=> col_reg == $past(col_reg) + COL_W'(1)
            && row_reg == $past(row_reg))
        else $error("column did not advance");

    // forwarding is only selected when the prefetch hit the written column
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && col_next != col_reg |=> !fwd_reg)
        else $error("stale forward select");

    // a row end moves to the first column
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && row_end |=> col_reg == '0)
        else $error("column not reset at row end");
`endif

endmodule

### dv/pixel_prediction_residual_tb.sv
// self-checking testbench for pixel_prediction_residual: directed table, then random phases
// depends on ppr_pkg and the rtl of the block; needs no files or arguments
module pixel_prediction_residual_tb;
    import ppr_pkg::*;

    localparam logic [2:0] MODE_SPARE_LO  = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI  = 3'd7;
    localparam int         RANDOM_WORDS   = 900;
    localparam int         PRESSURE_PHASE = 3;
    localparam int         HOLD_CYCLES    = 64;

    typedef enum logic {STEP_CFG, STEP_WORD} step_kind_t;

    typedef struct packed {
        step_kind_t              kind;
        reg_idx_t                idx;
        logic [CFG_W-1:0]        value;
        logic signed [SMP_W-1:0] smp;
        logic                    typed;
        out_word_t               want;
    } step_t;

    logic                    aclk;
    logic                    aresetn   = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]        cfg_index = REG_MODE;
    logic [CFG_W-1:0]        cfg_wdata = '0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    logic signed [SMP_W-1:0] s_sample  = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    logic signed [SMP_W-1:0] m_result;
    logic                    m_end_of_image;

    // shadow of the block: registers, position and neighbor pixels
    logic [2:0]       mode_reg   = MODE_LEFT;
    dir_t             dir_reg    = DIR_ENCODE;
    logic [CFG_W-1:0] width_reg  = 13'd256;
    logic [CFG_W-1:0] height_reg = 13'd256;
    logic [PIX_W-1:0] above_row [MAX_WIDTH] = '{default: '0};
    logic [PIX_W-1:0] left_px   = '0;
    logic [PIX_W-1:0] upleft_px = '0;
    int               col_pos   = 0;
    int               row_pos   = 0;

    out_word_t coded_words[$];
    int        fails        = 0;
    bit        hold_request = 1'b0;

    pixel_prediction_residual i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result       (m_result),
        .m_end_of_image (m_end_of_image)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAIL pixel_prediction_residual");
        $finish;
    end

    function automatic int fit_pixel(input int v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return v;
    endfunction

    function automatic int span(input logic [CFG_W-1:0] v, input int top);
        if (v == 0) return 1;
        if (v > top) return top;
        return v;
    endfunction

    function automatic int paeth_pick(input int l, input int a, input int ul);
        int base, dl, da, dul;
        base = l + a - ul;
        dl   = (base > l) ? base - l : l - base;
        da   = (base > a) ? base - a : a - base;
        dul  = (base > ul) ? base - ul : ul - base;
        if (dl <= da && dl <= dul) return l;
        if (da <= dul) return a;
        return ul;
    endfunction

    // codes one sample at the current position and advances the raster walk
    task automatic predict_code(input logic signed [SMP_W-1:0] smp, output out_word_t word);
        int  w, h, l, a, ul, guess, px, res;
        bit  row_end, img_end;
        w     = span(width_reg, MAX_WIDTH);
        h     = span(height_reg, MAX_HEIGHT);
        l     = (col_pos > 0) ? int'(left_px) : 0;
        a     = (row_pos > 0) ? int'(above_row[col_pos]) : 0;
        ul    = (col_pos > 0 && row_pos > 0) ? int'(upleft_px) : 0;
        case (mode_reg)
            MODE_LEFT:     guess = l;
            MODE_ABOVE:    guess = a;
            MODE_AVERAGE:  guess = (l + a) / 2;
            MODE_PAETH:    guess = paeth_pick(l, a, ul);
            MODE_GRADIENT: guess = l + a - ul;
            MODE_HALF:     guess = l + (a - ul) / 2;
            default:       guess = 0;
        endcase
        if (dir_reg == DIR_ENCODE) begin
            px  = fit_pixel(int'(smp));
            res = px - guess;
        end else begin
            px  = fit_pixel(guess + int'(smp));
            res = px;
        end
        upleft_px          = PIX_W'(a);
        left_px            = PIX_W'(px);
        above_row[col_pos] = PIX_W'(px);
        row_end = (col_pos + 1 >= w);
        img_end = row_end && (row_pos + 1 >= h);
        if (img_end) begin
            col_pos = 0;
            row_pos = 0;
        end else if (row_end) begin
            col_pos = 0;
            row_pos++;
        end else begin
            col_pos++;
        end
        word.result       = SMP_W'(res);
        word.end_of_image = img_end;
    endtask

    task automatic write_reg(input reg_idx_t idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MODE:      mode_reg   = value[2:0];
            REG_DIRECTION: dir_reg    = dir_t'(value[0]);
            REG_WIDTH:     width_reg  = value[CFG_W-1:0];
            REG_HEIGHT:    height_reg = value[CFG_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // valid stays up on return; the caller lowers it when it wants a gap
    task automatic send_word(input logic signed [SMP_W-1:0] smp, input bit typed = 1'b0,
                             input out_word_t typed_word = '0);
        out_word_t word;
        s_valid  <= 1'b1;
        s_sample <= smp;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_code(smp, word);
        coded_words.insert(coded_words.size(), typed ? typed_word : word);
    endtask

    task automatic drain_results();
        while (coded_words.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    function automatic logic signed [SMP_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return SMP_W'($urandom_range(0, 1023));
        if (dir_reg == DIR_DECODE) return SMP_W'(int'($urandom_range(0, 32)) - 16);
        if (r < 45) return SMP_W'(fit_pixel(int'(left_px) + int'($urandom_range(0, 16)) - 8));
        return SMP_W'($urandom_range(0, 255));
    endfunction

    function automatic int pick_extent();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 1;
            2:       return 4096;
            default: return 8191;
        endcase
    endfunction

    function automatic step_t cfg_row(input reg_idx_t idx, input int value);
        step_t s;
        s       = '0;
        s.kind  = STEP_CFG;
        s.idx   = idx;
        s.value = value[CFG_W-1:0];
        return s;
    endfunction

    function automatic step_t word_row(input int smp);
        step_t s;
        s      = '0;
        s.kind = STEP_WORD;
        s.smp  = SMP_W'(smp);
        return s;
    endfunction

    function automatic step_t typed_row(input int smp, input int res, input bit eoi);
        step_t s;
        s                   = word_row(smp);
        s.typed             = 1'b1;
        s.want.result       = SMP_W'(res);
        s.want.end_of_image = eoi;
        return s;
    endfunction

    always @(posedge aclk) begin : result_check
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (coded_words.size() == 0) begin
                $error("result word with nothing expected: result %0d", m_result);
                fails++;
            end else begin
                want = coded_words.pop_front();
                if (m_result !== want.result) begin
                    $error("result: expected %0d, actual %0d", want.result, m_result);
                    fails++;
                end
                if (m_end_of_image !== want.end_of_image) begin
                    $error("end_of_image: expected %0d, actual %0d",
                           want.end_of_image, m_end_of_image);
                    fails++;
                end
            end
        end
    end

    // receiver: stall density changes per segment, plus one long hold on request
    initial begin : receiver
        int seg, pct;
        wait (aresetn);
        forever begin
            seg = $urandom_range(20, 200);
            case ($urandom_range(0, 4))
                0, 1:    pct = 0;
                2:       pct = 30;
                3:       pct = 60;
                default: pct = 90;
            endcase
            repeat (seg) begin
                if (hold_request) begin
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                    hold_request = 1'b0;
                end
                m_ready <= ($urandom_range(0, 99) >= pct);
                @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        step_t            directed_steps[$];
        step_t            st;
        logic [CFG_W-1:0] next_w, next_h;
        int               phase, words, random_words, burst_left;
        bit               steady;

        phase        = 0;
        random_words = 0;
        burst_left   = 1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // 3x2 images; the first is in the power-on mode and its expected results are in the table
        directed_steps = '{
            cfg_row(REG_WIDTH, 3),          cfg_row(REG_HEIGHT, 2),
            typed_row(0, 0, 0),             typed_row(255, 255, 0),
            typed_row(-510, -255, 0),       typed_row(300, 255, 0),
            typed_row(-512, -255, 0),       typed_row(511, 255, 1),
            cfg_row(REG_MODE, MODE_PAETH),
            word_row(200),                  word_row(17),              word_row(128),
            cfg_row(REG_MODE, MODE_ABOVE),  word_row(90),
            cfg_row(REG_MODE, MODE_AVERAGE), word_row(33),
            cfg_row(REG_MODE, MODE_PAETH),  word_row(250),
            cfg_row(REG_MODE, MODE_GRADIENT),
            word_row(10),                   word_row(240),             word_row(5),
            cfg_row(REG_MODE, MODE_HALF),   word_row(255),
            cfg_row(REG_MODE, MODE_SPARE_LO), word_row(7),
            cfg_row(REG_MODE, MODE_SPARE_HI), word_row(128),
            cfg_row(REG_DIRECTION, DIR_DECODE), cfg_row(REG_MODE, MODE_LEFT),
            typed_row(-510, 0, 0),          typed_row(510, 255, 0),
            cfg_row(REG_MODE, MODE_GRADIENT),
            word_row(-3),                   word_row(4),
            word_row(511),                  word_row(-512)
        };

        foreach (directed_steps[i]) begin
            st = directed_steps[i];
            if (st.kind == STEP_CFG) begin
                s_valid <= 1'b0;
                drain_results();
                write_reg(st.idx, int'(st.value));
            end else begin
                send_word(st.smp, st.typed, st.want);
            end
        end

        while (random_words < RANDOM_WORDS) begin
            phase++;
            s_valid <= 1'b0;
            drain_results();
            next_w = width_reg;
            next_h = height_reg;
            if ($urandom_range(0, 1) == 0) begin
                if ($urandom_range(0, 4) == 0) begin
                    next_w = CFG_W'(pick_extent());
                    next_h = CFG_W'(pick_extent());
                end else begin
                    next_w = CFG_W'($urandom_range(1, 8));
                    next_h = CFG_W'($urandom_range(1, 5));
                end
            end
            // columns past the old width hold nothing from this image, so close it first
            if (span(next_w, MAX_WIDTH) > span(width_reg, MAX_WIDTH) &&
                (col_pos != 0 || row_pos != 0)) begin
                write_reg(REG_WIDTH, 1);
                write_reg(REG_HEIGHT, 1);
                send_word(pick_sample());
                s_valid <= 1'b0;
                drain_results();
            end
            write_reg(REG_MODE, int'($urandom_range(0, 7)));
            write_reg(REG_DIRECTION, int'($urandom_range(0, 1)));
            write_reg(REG_WIDTH, int'(next_w));
            write_reg(REG_HEIGHT, int'(next_h));

            steady = (phase == PRESSURE_PHASE) || ($urandom_range(0, 3) == 0);
            if (phase == PRESSURE_PHASE)
                words = 60;
            else if (span(width_reg, MAX_WIDTH) > 64)
                words = $urandom_range(5, 40);
            else
                words = $urandom_range(10, 60);
            if (phase == PRESSURE_PHASE)
                hold_request = 1'b1;

            repeat (words) begin
                send_word(pick_sample());
                random_words++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    if (!steady) begin
                        s_valid <= 1'b0;
                        repeat ($urandom_range(1, 8)) @(posedge aclk);
                    end
                end
            end
        end

        s_valid <= 1'b0;
        drain_results();
        repeat (8) @(posedge aclk);
        if (fails == 0)
            $display("PASS pixel_prediction_residual");
        else
            $display("FAIL pixel_prediction_residual");
        $finish;
    end

endmodule
